// ----- rtl/plbba_pkg.sv -----
`default_nettype none
package plbba_pkg;
  localparam int IDX_W = 12;
  localparam int QTY_W = 32;
  localparam int WORD_W = 64;
  localparam int WADDR_W = 6;
  localparam int BUCKETS = 16;
  localparam int BUCKET_WORDS = 4;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_MODIFY = 3'd1;
  localparam logic [2:0] OP_CANCEL = 3'd2;
  localparam logic [2:0] OP_TRADE = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  typedef struct packed {
    logic [2:0] operation;
    logic side;
    logic [IDX_W-1:0] price_index;
    logic [QTY_W-1:0] quantity;
  } in_item_t;

  typedef struct packed {
    logic bid_valid;
    logic [IDX_W-1:0] bid_index;
    logic [QTY_W-1:0] bid_amount;
    logic ask_valid;
    logic [IDX_W-1:0] ask_index;
    logic [QTY_W-1:0] ask_amount;
  } out_item_t;

  function automatic logic [5:0] top_bit64(input logic [WORD_W-1:0] w);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) if (w[i]) n = 6'(i);
    return n;
  endfunction

  function automatic logic [5:0] low_bit64(input logic [WORD_W-1:0] w);
    logic [5:0] n;
    n = 6'd63;
    for (int i = WORD_W - 1; i >= 0; i--) if (w[i]) n = 6'(i);
    return n;
  endfunction

  function automatic logic [3:0] top_bit16(input logic [BUCKETS-1:0] w);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < BUCKETS; i++) if (w[i]) n = 4'(i);
    return n;
  endfunction

  function automatic logic [3:0] low_bit16(input logic [BUCKETS-1:0] w);
    logic [3:0] n;
    n = '0;
    for (int i = BUCKETS - 1; i >= 0; i--) if (w[i]) n = 4'(i);
    return n;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/price_level_book_best_bid_ask.sv -----
`default_nettype none
// Price-level book with best bid / best ask. Pulse start with an update
// transaction while busy is low; busy rises for the update and the result
// appears on out_* for exactly one cycle with out_valid. Each side holds a
// 64-word level bitmap and a 4096-entry amount memory, both synchronous
// reads. An update steps through: read the addressed word and amount,
// write back, read the best bitmap word per side, read the best amount,
// then present. No reset sweep is needed: per-word nonzero flags, cleared
// at reset and by clear, mark the bitmap words that hold data. The receiver
// cannot stall; results are never held off.
module price_level_book_best_bid_ask (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire plbba_pkg::in_item_t   in_item,
  output logic                       out_valid,
  output plbba_pkg::out_item_t       out_item
);
  typedef enum logic [2:0] {S_IDLE, S_READ, S_WRITE, S_BWORD, S_BAMT, S_OUT} state_t;
  state_t state_r;
  plbba_pkg::in_item_t req_r;

  logic [1:0] rd_en, wr_en;
  logic [plbba_pkg::IDX_W-1:0] rd_idx [2];
  logic [plbba_pkg::QTY_W-1:0] wr_qty;
  logic [plbba_pkg::WORD_W-1:0] rd_word [2];
  logic [plbba_pkg::QTY_W-1:0] rd_amt [2];
  logic [1:0] bvalid;
  logic [plbba_pkg::IDX_W-1:0] bidx [2];
  logic clear;
  logic [plbba_pkg::IDX_W-1:0] best_r [2];
  logic [1:0] bvalid_r;

  logic cur_active;
  logic [plbba_pkg::QTY_W-1:0] cur_amt;
  logic do_write;

  assign cur_active = rd_word[req_r.side][req_r.price_index[5:0]];
  assign cur_amt = rd_amt[req_r.side];

  // Decide the new amount for the addressed level.
  always_comb begin
    do_write = 1'b0;
    wr_qty = '0;
    case (req_r.operation)
      plbba_pkg::OP_ADD, plbba_pkg::OP_MODIFY: begin
        do_write = 1'b1;
        wr_qty = req_r.quantity;
      end
      plbba_pkg::OP_CANCEL: do_write = 1'b1;
      plbba_pkg::OP_TRADE: begin
        do_write = cur_active;
        wr_qty = (req_r.quantity >= cur_amt) ? '0 : cur_amt - req_r.quantity;
      end
      default: do_write = 1'b0;
    endcase
  end

  assign clear = (state_r == S_WRITE) && (req_r.operation == plbba_pkg::OP_CLEAR);

  always_comb begin
    rd_en = '0;
    wr_en = '0;
    for (int s = 0; s < 2; s++) rd_idx[s] = req_r.price_index;
    unique case (state_r)
      S_READ: rd_en[req_r.side] = 1'b1;
      S_WRITE: wr_en[req_r.side] = do_write;
      S_BWORD: begin
        rd_en = 2'b11;
        for (int s = 0; s < 2; s++) rd_idx[s] = {bidx[s][11:6], 6'd0};
      end
      S_BAMT: begin
        rd_en = 2'b11;
        for (int s = 0; s < 2; s++) rd_idx[s] = bidx[s];
      end
      default: ;
    endcase
  end

  for (genvar s = 0; s < 2; s++) begin : g_side
    plbba_side u_side (
      .clk(clk), .rst_n(rst_n), .high_best(s == 0),
      .rd_en(rd_en[s]), .rd_idx(rd_idx[s]),
      .wr_en(wr_en[s]), .wr_idx(req_r.price_index), .wr_qty(wr_qty),
      .clear(clear),
      .rd_word(rd_word[s]), .rd_amt(rd_amt[s]),
      .best_valid(bvalid[s]), .best_idx(bidx[s])
    );
  end

  // Sequence one update; hold results one cycle on out_*.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      busy <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          req_r <= in_item;
          busy <= 1'b1;
          state_r <= S_READ;
        end
        S_READ: state_r <= S_WRITE;
        S_WRITE: state_r <= S_BWORD;
        S_BWORD: state_r <= S_BAMT;
        S_BAMT: begin
          // word now in rd_word: latch the full best index
          best_r[0] <= bidx[0];
          best_r[1] <= bidx[1];
          bvalid_r <= bvalid;
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_item.bid_valid <= bvalid_r[0];
          out_item.bid_index <= bvalid_r[0] ? best_r[0] : '0;
          out_item.bid_amount <= bvalid_r[0] ? rd_amt[0] : '0;
          out_item.ask_valid <= bvalid_r[1];
          out_item.ask_index <= bvalid_r[1] ? best_r[1] : '0;
          out_item.ask_amount <= bvalid_r[1] ? rd_amt[1] : '0;
          busy <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not raise busy");
  a_bid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.bid_valid) |-> (out_item.bid_amount == '0))
    else $error("bid amount nonzero when invalid");
endmodule
`default_nettype wire

// ----- rtl/plbba_side.sv -----
`default_nettype none
// One book side: level-bit word memory, amount memory, bucket summary.
// Sequenced by the top level through read and write strobes.
module plbba_side (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        high_best,  // 1: bids (highest)
  input  wire logic                        rd_en,      // read word+amount at addr
  input  wire logic [plbba_pkg::IDX_W-1:0] rd_idx,
  input  wire logic                        wr_en,
  input  wire logic [plbba_pkg::IDX_W-1:0] wr_idx,
  input  wire logic [plbba_pkg::QTY_W-1:0] wr_qty,
  input  wire logic                        clear,
  output logic [plbba_pkg::WORD_W-1:0]     rd_word,
  output logic [plbba_pkg::QTY_W-1:0]      rd_amt,
  output logic                             best_valid,
  output logic [plbba_pkg::IDX_W-1:0]      best_idx
);
  logic [plbba_pkg::WORD_W-1:0] words_mem [64];
  logic [plbba_pkg::QTY_W-1:0] amt_mem [4096];
  logic [63:0] word_nz_r;          // one flag per word: nonzero
  logic [plbba_pkg::BUCKETS-1:0] summ;
  logic [3:0] bkt;
  logic [1:0] wsel;
  logic [5:0] waddr_best;

  // Word valid flags double as cleared state for the word memory.
  logic [plbba_pkg::WORD_W-1:0] word_raw;
  logic word_ok_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      word_raw <= words_mem[rd_idx[11:6]];
      rd_amt <= amt_mem[rd_idx];
    end
    if (wr_en) amt_mem[wr_idx] <= wr_qty;
  end

  logic [plbba_pkg::WORD_W-1:0] wr_word;
  always_comb begin
    wr_word = rd_word;
    wr_word[wr_idx[5:0]] = (wr_qty != '0);
  end

  always_ff @(posedge clk) begin
    if (wr_en) words_mem[wr_idx[11:6]] <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) word_nz_r <= '0;
    else if (wr_en) word_nz_r[wr_idx[11:6]] <= (wr_word != '0);
    if (rd_en) word_ok_r <= rst_n && !clear && word_nz_r[rd_idx[11:6]];
  end
  assign rd_word = word_ok_r ? word_raw : '0;

  // Summary and best index: derived from nonzero flags, then best word read.
  always_comb begin
    for (int b = 0; b < plbba_pkg::BUCKETS; b++) summ[b] = |word_nz_r[b*4 +: 4];
    bkt = high_best ? plbba_pkg::top_bit16(summ) : plbba_pkg::low_bit16(summ);
    wsel = '0;
    if (high_best) begin
      for (int i = 0; i < 4; i++) if (word_nz_r[{bkt, 2'(i)}]) wsel = 2'(i);
    end else begin
      for (int i = 3; i >= 0; i--) if (word_nz_r[{bkt, 2'(i)}]) wsel = 2'(i);
    end
    waddr_best = {bkt, wsel};
  end

  assign best_valid = |summ;
  // Best word is fetched by the top level via rd_idx; bit index from rd_word.
  assign best_idx = {waddr_best,
                     high_best ? plbba_pkg::top_bit64(rd_word) : plbba_pkg::low_bit64(rd_word)};
endmodule
`default_nettype wire
